// ----- src/lsc_pkg.sv -----
package lsc_pkg;

  // Input operation classes.
  localparam logic [2:0] OC_OTHER = 3'd0;
  localparam logic [2:0] OC_LDP   = 3'd1;
  localparam logic [2:0] OC_STP   = 3'd2;
  localparam logic [2:0] OC_LDR   = 3'd3;
  localparam logic [2:0] OC_STR   = 3'd4;

  // Addressing modes.
  localparam logic [1:0] AM_OFFSET = 2'd0;
  localparam logic [1:0] AM_POST   = 2'd1;
  localparam logic [1:0] AM_PRE    = 2'd2;

  // Micro-op kinds on the result channel.
  localparam logic [2:0] UK_WHOLE = 3'd0;
  localparam logic [2:0] UK_LDA   = 3'd1;
  localparam logic [2:0] UK_STA   = 3'd2;
  localparam logic [2:0] UK_STD   = 3'd3;
  localparam logic [2:0] UK_OFF   = 3'd4;

  // Register 31 means the zero register or SP depending on context.
  localparam logic [4:0] REG_SPECIAL = 5'd31;

  localparam int LSC_MAX_UOPS    = 5;
  localparam int LSC_STEP_W      = 3;
  localparam int LSC_QUEUE_DEPTH = 2;

  // One slot of the micro-op program built by the front end.
  typedef enum logic [2:0] {
    SL_WHOLE,
    SL_OFF,
    SL_E1_LD,
    SL_E2_LD,
    SL_E1_STA,
    SL_E1_STD,
    SL_E2_STA,
    SL_E2_STD
  } slot_t;

  typedef struct packed {
    logic [31:0]                     word;
    logic [4:0]                      base;
    logic [4:0]                      size;
    logic signed [17:0]              wb_offset;
    logic [4:0]                      reg_a;
    logic                            fp_a;
    logic signed [17:0]              ofs_a;
    logic [4:0]                      reg_b;
    logic                            fp_b;
    logic signed [17:0]              ofs_b;
    slot_t [LSC_MAX_UOPS-1:0]        slots;
    logic [LSC_STEP_W-1:0]           num_slots;
  } lsc_desc_t;

endpackage

// ----- src/lsc_front.sv -----
module lsc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic [31:0]        instr_word,
  input  logic [2:0]         op_class,
  input  logic [1:0]         addr_mode,
  input  logic [4:0]         data_size,
  input  logic [4:0]         first_reg,
  input  logic               first_is_fp,
  input  logic [4:0]         second_reg,
  input  logic               second_is_fp,
  input  logic [4:0]         base_reg,
  input  logic signed [16:0] offset,
  output lsc_pkg::lsc_desc_t desc
);
  import lsc_pkg::*;

  logic split_en_r;
  logic split_en_nxt;

  always_comb begin
    split_en_nxt = cfg_wr_en ? cfg_wr_data : split_en_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      split_en_r <= 1'b1;
    end else begin
      split_en_r <= split_en_nxt;
    end
  end

  always_comb begin
    logic               whole;
    logic               pair;
    logic               load;
    logic               swap;
    logic signed [17:0] a1;
    logic signed [17:0] a2;
    logic [LSC_STEP_W-1:0] n;

    pair  = (op_class == OC_LDP) || (op_class == OC_STP);
    load  = (op_class == OC_LDP) || (op_class == OC_LDR);
    whole = !split_en_r || (op_class == OC_OTHER) || (op_class > OC_STR) ||
            (addr_mode > AM_PRE) || ((op_class == OC_LDR) && (addr_mode == AM_OFFSET));

    // Pre- and post-index forms address from the base itself.
    a1 = (addr_mode == AM_OFFSET) ? 18'(offset) : 18'sd0;
    a2 = a1 + $signed({13'd0, data_size});

    // A load pair in offset mode whose first destination overwrites the base loads it last.
    swap = (addr_mode == AM_OFFSET) && load && pair && !first_is_fp &&
           (first_reg != REG_SPECIAL) && (first_reg == base_reg);

    desc.word      = instr_word;
    desc.base      = base_reg;
    desc.size      = data_size;
    desc.wb_offset = 18'(offset);
    desc.reg_a     = swap ? second_reg   : first_reg;
    desc.fp_a      = swap ? second_is_fp : first_is_fp;
    desc.ofs_a     = swap ? a2 : a1;
    desc.reg_b     = swap ? first_reg    : second_reg;
    desc.fp_b      = swap ? first_is_fp  : second_is_fp;
    desc.ofs_b     = swap ? a1 : a2;

    desc.slots = {LSC_MAX_UOPS{SL_WHOLE}};
    n = '0;
    if (whole) begin
      n = LSC_STEP_W'(1);
    end else begin
      if (addr_mode == AM_PRE) begin
        desc.slots[n] = SL_OFF;
        n = n + LSC_STEP_W'(1);
      end
      if (load) begin
        desc.slots[n] = SL_E1_LD;
        n = n + LSC_STEP_W'(1);
        if (pair) begin
          desc.slots[n] = SL_E2_LD;
          n = n + LSC_STEP_W'(1);
        end
      end else begin
        desc.slots[n] = SL_E1_STA;
        n = n + LSC_STEP_W'(1);
        desc.slots[n] = SL_E1_STD;
        n = n + LSC_STEP_W'(1);
        if (pair) begin
          desc.slots[n] = SL_E2_STA;
          n = n + LSC_STEP_W'(1);
          desc.slots[n] = SL_E2_STD;
          n = n + LSC_STEP_W'(1);
        end
      end
      if (addr_mode == AM_POST) begin
        desc.slots[n] = SL_OFF;
        n = n + LSC_STEP_W'(1);
      end
    end
    desc.num_slots = n;
  end

endmodule

// ----- src/lsc_queue.sv -----
module lsc_queue #(
  parameter int QUEUE_DEPTH = lsc_pkg::LSC_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  lsc_pkg::lsc_desc_t wr_desc,
  output logic               full,
  input  logic               rd_en,
  output logic               rd_valid,
  output lsc_pkg::lsc_desc_t rd_desc
);
  import lsc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  lsc_desc_t        mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_desc  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_desc;
    end
  end

endmodule

// ----- src/lsc_back.sv -----
module lsc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               desc_valid,
  input  lsc_pkg::lsc_desc_t desc,
  output logic               desc_done,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         uop_kind,
  output logic [31:0]        out_word,
  output logic [4:0]         uop_reg,
  output logic               uop_reg_is_fp,
  output logic [4:0]         uop_base,
  output logic signed [17:0] uop_offset,
  output logic [4:0]         uop_size,
  output logic [1:0]         pair_index,
  output logic               last_uop
);
  import lsc_pkg::*;

  logic [LSC_STEP_W-1:0] step_r, step_nxt;
  logic                  valid_r, valid_nxt;
  logic                  emit;
  logic                  is_last;
  slot_t                 slot;

  logic [2:0]         kind_c;
  logic [4:0]         reg_c;
  logic               fp_c;
  logic [4:0]         base_c;
  logic signed [17:0] ofs_c;
  logic [4:0]         size_c;
  logic [1:0]         pidx_c;

  logic [2:0]         kind_r;
  logic [31:0]        word_r;
  logic [4:0]         reg_r;
  logic               fp_r;
  logic [4:0]         base_r;
  logic signed [17:0] ofs_r;
  logic [4:0]         size_r;
  logic [1:0]         pidx_r;
  logic               last_r;

  // The output register takes a new micro-op when a descriptor waits and it is free or being drained.
  assign emit      = desc_valid && (!valid_r || pop);
  assign slot      = desc.slots[step_r];
  assign is_last   = (step_r == desc.num_slots - LSC_STEP_W'(1));
  assign desc_done = emit && is_last;

  always_comb begin
    kind_c = UK_WHOLE;
    reg_c  = '0;
    fp_c   = 1'b0;
    base_c = '0;
    ofs_c  = '0;
    size_c = '0;
    pidx_c = 2'd0;
    unique case (slot)
      SL_WHOLE: begin
        kind_c = UK_WHOLE;
      end
      SL_OFF: begin
        kind_c = UK_OFF;
        reg_c  = desc.base;
        base_c = desc.base;
        ofs_c  = desc.wb_offset;
      end
      SL_E1_LD: begin
        kind_c = UK_LDA;
        reg_c  = desc.reg_a;
        fp_c   = desc.fp_a;
        base_c = desc.base;
        ofs_c  = desc.ofs_a;
        size_c = desc.size;
        pidx_c = 2'd1;
      end
      SL_E2_LD: begin
        kind_c = UK_LDA;
        reg_c  = desc.reg_b;
        fp_c   = desc.fp_b;
        base_c = desc.base;
        ofs_c  = desc.ofs_b;
        size_c = desc.size;
        pidx_c = 2'd2;
      end
      SL_E1_STA: begin
        kind_c = UK_STA;
        base_c = desc.base;
        ofs_c  = desc.ofs_a;
        size_c = desc.size;
        pidx_c = 2'd1;
      end
      SL_E1_STD: begin
        kind_c = UK_STD;
        reg_c  = desc.reg_a;
        fp_c   = desc.fp_a;
        pidx_c = 2'd1;
      end
      SL_E2_STA: begin
        kind_c = UK_STA;
        base_c = desc.base;
        ofs_c  = desc.ofs_b;
        size_c = desc.size;
        pidx_c = 2'd2;
      end
      SL_E2_STD: begin
        kind_c = UK_STD;
        reg_c  = desc.reg_b;
        fp_c   = desc.fp_b;
        pidx_c = 2'd2;
      end
      default: begin
        kind_c = UK_WHOLE;
      end
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    if (emit) begin
      step_nxt = is_last ? '0 : step_r + LSC_STEP_W'(1);
    end
    valid_nxt = valid_r;
    if (emit) begin
      valid_nxt = 1'b1;
    end else if (pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r <= kind_c;
      word_r <= desc.word;
      reg_r  <= reg_c;
      fp_r   <= fp_c;
      base_r <= base_c;
      ofs_r  <= ofs_c;
      size_r <= size_c;
      pidx_r <= pidx_c;
      last_r <= is_last;
    end
  end

  assign empty         = !valid_r;
  assign uop_kind      = kind_r;
  assign out_word      = word_r;
  assign uop_reg       = reg_r;
  assign uop_reg_is_fp = fp_r;
  assign uop_base      = base_r;
  assign uop_offset    = ofs_r;
  assign uop_size      = size_r;
  assign pair_index    = pidx_r;
  assign last_uop      = last_r;

endmodule

// ----- src/load_store_uop_cracker_top.sv -----
// Path: the first micro-op of an instruction reaches the result ports through the descriptor
// queue and the output register; each further micro-op follows the one before in order.
// Throughput: one micro-op per cycle from the sequencer while the output is free or popped;
// an instruction holds it for one to five micro-ops, so unsplit items flow at one per cycle.
// A descriptor queue of QUEUE_DEPTH entries lets intake continue while the sequencer works.
// Reset (synchronous, rst_n low) empties the queue and output register and sets split_enable.
module load_store_uop_cracker_top #(
  parameter int QUEUE_DEPTH = lsc_pkg::LSC_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               push,
  output logic               full,
  input  logic [31:0]        in_instr_word,
  input  logic [2:0]         in_op_class,
  input  logic [1:0]         in_addr_mode,
  input  logic [4:0]         in_data_size,
  input  logic [4:0]         in_first_reg,
  input  logic               in_first_is_fp,
  input  logic [4:0]         in_second_reg,
  input  logic               in_second_is_fp,
  input  logic [4:0]         in_base_reg,
  input  logic signed [16:0] in_offset,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         out_uop_kind,
  output logic [31:0]        out_out_word,
  output logic [4:0]         out_uop_reg,
  output logic               out_uop_reg_is_fp,
  output logic [4:0]         out_uop_base,
  output logic signed [17:0] out_uop_offset,
  output logic [4:0]         out_uop_size,
  output logic [1:0]         out_pair_index,
  output logic               out_last_uop
);
  import lsc_pkg::*;

  lsc_desc_t front_desc;
  lsc_desc_t head_desc;
  logic      head_valid;
  logic      head_done;
  logic      push_xfer;

  assign push_xfer = push && !full;

  lsc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .instr_word   (in_instr_word),
    .op_class     (in_op_class),
    .addr_mode    (in_addr_mode),
    .data_size    (in_data_size),
    .first_reg    (in_first_reg),
    .first_is_fp  (in_first_is_fp),
    .second_reg   (in_second_reg),
    .second_is_fp (in_second_is_fp),
    .base_reg     (in_base_reg),
    .offset       (in_offset),
    .desc         (front_desc)
  );

  lsc_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push_xfer),
    .wr_desc  (front_desc),
    .full     (full),
    .rd_en    (head_done),
    .rd_valid (head_valid),
    .rd_desc  (head_desc)
  );

  lsc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .desc_valid    (head_valid),
    .desc          (head_desc),
    .desc_done     (head_done),
    .empty         (empty),
    .pop           (pop),
    .uop_kind      (out_uop_kind),
    .out_word      (out_out_word),
    .uop_reg       (out_uop_reg),
    .uop_reg_is_fp (out_uop_reg_is_fp),
    .uop_base      (out_uop_base),
    .uop_offset    (out_uop_offset),
    .uop_size      (out_uop_size),
    .pair_index    (out_pair_index),
    .last_uop      (out_last_uop)
  );

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import lsc_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  cls;
    logic [1:0]  mode;
    logic [4:0]  dsize;
    logic [4:0]  r1;
    logic        f1;
    logic [4:0]  r2;
    logic        f2;
    logic [4:0]  base;
    logic [16:0] ofs;
    logic        unsplit;
  } stim_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [31:0]        word;
    logic [4:0]         dreg;
    logic               fp;
    logic [4:0]         base;
    logic signed [17:0] ofs;
    logic [4:0]         size;
    logic [1:0]         pidx;
    logic               last;
  } uop_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] in_instr_word = '0;
  logic [2:0]  in_op_class = '0;
  logic [1:0]  in_addr_mode = '0;
  logic [4:0]  in_data_size = '0;
  logic [4:0]  in_first_reg = '0;
  logic        in_first_is_fp = 1'b0;
  logic [4:0]  in_second_reg = '0;
  logic        in_second_is_fp = 1'b0;
  logic [4:0]  in_base_reg = '0;
  logic signed [16:0] in_offset = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  out_uop_kind;
  logic [31:0] out_out_word;
  logic [4:0]  out_uop_reg;
  logic        out_uop_reg_is_fp;
  logic [4:0]  out_uop_base;
  logic signed [17:0] out_uop_offset;
  logic [4:0]  out_uop_size;
  logic [1:0]  out_pair_index;
  logic        out_last_uop;

  // Marks an item whose unsplit result is typed into the directed table.
  logic        typed_unsplit = 1'b0;

  logic  split_model = 1'b1;
  uop_t  uops_pending[$];
  stim_t directed_rows[$];
  int    mismatches = 0;
  int    quiet_cycles = 0;
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;

  load_store_uop_cracker_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .push              (push),
    .full              (full),
    .in_instr_word     (in_instr_word),
    .in_op_class       (in_op_class),
    .in_addr_mode      (in_addr_mode),
    .in_data_size      (in_data_size),
    .in_first_reg      (in_first_reg),
    .in_first_is_fp    (in_first_is_fp),
    .in_second_reg     (in_second_reg),
    .in_second_is_fp   (in_second_is_fp),
    .in_base_reg       (in_base_reg),
    .in_offset         (in_offset),
    .empty             (empty),
    .pop               (pop),
    .out_uop_kind      (out_uop_kind),
    .out_out_word      (out_out_word),
    .out_uop_reg       (out_uop_reg),
    .out_uop_reg_is_fp (out_uop_reg_is_fp),
    .out_uop_base      (out_uop_base),
    .out_uop_offset    (out_uop_offset),
    .out_uop_size      (out_uop_size),
    .out_pair_index    (out_pair_index),
    .out_last_uop      (out_last_uop)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic stim_t mk_stim(logic [31:0] word, logic [2:0] cls, logic [1:0] mode,
                                    logic [4:0] dsize, logic [4:0] r1, logic f1,
                                    logic [4:0] r2, logic f2, logic [4:0] base,
                                    logic [16:0] ofs, logic unsplit);
    stim_t s;
    s.word = word;
    s.cls = cls;
    s.mode = mode;
    s.dsize = dsize;
    s.r1 = r1;
    s.f1 = f1;
    s.r2 = r2;
    s.f2 = f2;
    s.base = base;
    s.ofs = ofs;
    s.unsplit = unsplit;
    return s;
  endfunction

  function automatic void add_row(stim_t s);
    directed_rows = {directed_rows, s};
  endfunction

  function automatic uop_t mk_uop(logic [2:0] kind, logic [31:0] word, logic [4:0] dreg,
                                  logic fp, logic [4:0] base, logic signed [17:0] ofs,
                                  logic [4:0] size, logic [1:0] pidx);
    uop_t u;
    u.kind = kind;
    u.word = word;
    u.dreg = dreg;
    u.fp = fp;
    u.base = base;
    u.ofs = ofs;
    u.size = size;
    u.pidx = pidx;
    u.last = 1'b0;
    return u;
  endfunction

  // Expands one instruction into its micro-ops and queues them in order.
  function automatic void crack_instr(stim_t it);
    uop_t               seq[$];
    logic signed [17:0] ofs18;
    logic signed [17:0] ofs_lo;
    logic signed [17:0] ofs_hi;
    logic               is_pair;
    logic               is_load;
    logic               swap_pair;
    ofs18 = 18'($signed(it.ofs));
    is_pair = (it.cls == OC_LDP) || (it.cls == OC_STP);
    is_load = (it.cls == OC_LDP) || (it.cls == OC_LDR);
    if (!split_model || it.cls == OC_OTHER || it.cls > OC_STR || it.mode > AM_PRE ||
        (it.cls == OC_LDR && it.mode == AM_OFFSET)) begin
      seq = {seq, mk_uop(UK_WHOLE, it.word, '0, 1'b0, '0, '0, '0, '0)};
    end else begin
      // With writeback the addresses are relative to the updated or original base.
      if (it.mode == AM_OFFSET) begin
        ofs_lo = ofs18;
        ofs_hi = ofs18 + $signed({13'b0, it.dsize});
      end else begin
        ofs_lo = '0;
        ofs_hi = $signed({13'b0, it.dsize});
      end
      if (it.mode == AM_PRE)
        seq = {seq, mk_uop(UK_OFF, it.word, it.base, 1'b0, it.base, ofs18, '0, '0)};
      if (is_load) begin
        // A load pair in offset mode that overwrites its own base loads the second element first.
        swap_pair = is_pair && it.mode == AM_OFFSET && !it.f1 &&
                    it.r1 != REG_SPECIAL && it.r1 == it.base;
        if (swap_pair)
          seq = {seq, mk_uop(UK_LDA, it.word, it.r2, it.f2, it.base, ofs_hi, it.dsize,
                             2'd1)};
        seq = {seq, mk_uop(UK_LDA, it.word, it.r1, it.f1, it.base, ofs_lo, it.dsize,
                           swap_pair ? 2'd2 : 2'd1)};
        if (is_pair && !swap_pair)
          seq = {seq, mk_uop(UK_LDA, it.word, it.r2, it.f2, it.base, ofs_hi, it.dsize,
                             2'd2)};
      end else begin
        seq = {seq, mk_uop(UK_STA, it.word, '0, 1'b0, it.base, ofs_lo, it.dsize, 2'd1)};
        seq = {seq, mk_uop(UK_STD, it.word, it.r1, it.f1, '0, '0, '0, 2'd1)};
        if (is_pair) begin
          seq = {seq, mk_uop(UK_STA, it.word, '0, 1'b0, it.base, ofs_hi, it.dsize, 2'd2)};
          seq = {seq, mk_uop(UK_STD, it.word, it.r2, it.f2, '0, '0, '0, 2'd2)};
        end
      end
      if (it.mode == AM_POST)
        seq = {seq, mk_uop(UK_OFF, it.word, it.base, 1'b0, it.base, ofs18, '0, '0)};
    end
    seq[seq.size() - 1].last = 1'b1;
    uops_pending = {uops_pending, seq};
  endfunction

  // Mostly well-formed loads and stores; the rest covers every encoding the fields allow.
  function automatic stim_t rand_stim();
    stim_t s;
    s.word = $urandom;
    if ($urandom_range(9) < 8) begin
      s.cls = 3'($urandom_range(OC_LDP, OC_STR));
      s.mode = 2'($urandom_range(AM_PRE));
    end else begin
      s.cls = 3'($urandom_range(7));
      s.mode = 2'($urandom_range(3));
    end
    if ($urandom_range(3) == 0)
      s.dsize = 5'($urandom_range(31));
    else
      s.dsize = 5'(1 << $urandom_range(4));
    s.r1 = 5'($urandom_range(31));
    s.f1 = 1'($urandom);
    s.r2 = 5'($urandom_range(31));
    s.f2 = 1'($urandom);
    s.base = ($urandom_range(3) == 0) ? s.r1 : 5'($urandom_range(31));
    case ($urandom_range(7))
      0: s.ofs = 17'h10000;
      1: s.ofs = 17'h0FFFF;
      default: s.ofs = 17'($urandom);
    endcase
    s.unsplit = 1'b0;
    return s;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  // Transfers one instruction; returns in the time step where it was accepted.
  task automatic send_instr(stim_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    typed_unsplit <= s.unsplit;
    in_instr_word <= s.word;
    in_op_class <= s.cls;
    in_addr_mode <= s.mode;
    in_data_size <= s.dsize;
    in_first_reg <= s.r1;
    in_first_is_fp <= s.f1;
    in_second_reg <= s.r2;
    in_second_is_fp <= s.f2;
    in_base_reg <= s.base;
    in_offset <= s.ofs;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (uops_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_split(logic en);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= en;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Samples both channels at the edge, checks results and predicts accepted items.
  always @(posedge clk) begin : monitor
    uop_t got;
    uop_t want;
    if ((push && !full) || (pop && !empty))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (!rst_n) begin
      split_model = 1'b1;
    end else begin
      if (cfg_wr_en)
        split_model = cfg_wr_data;
      if (pop && !empty) begin
        got = mk_uop(out_uop_kind, out_out_word, out_uop_reg, out_uop_reg_is_fp,
                     out_uop_base, out_uop_offset, out_uop_size, out_pair_index);
        got.last = out_last_uop;
        if (uops_pending.size() == 0) begin
          report_mismatch($sformatf("micro-op with word 0x%0h arrived with none pending",
                                    got.word));
        end else begin
          want = uops_pending.pop_front();
          check_field("uop_kind", 32'(got.kind), 32'(want.kind));
          check_field("out_word", got.word, want.word);
          check_field("uop_reg", 32'(got.dreg), 32'(want.dreg));
          check_field("uop_reg_is_fp", 32'(got.fp), 32'(want.fp));
          check_field("uop_base", 32'(got.base), 32'(want.base));
          check_field("uop_offset", 32'(got.ofs), 32'(want.ofs));
          check_field("uop_size", 32'(got.size), 32'(want.size));
          check_field("pair_index", 32'(got.pidx), 32'(want.pidx));
          check_field("last_uop", 32'(got.last), 32'(want.last));
        end
      end
      if (push && !full) begin
        if (typed_unsplit) begin
          want = mk_uop(UK_WHOLE, in_instr_word, '0, 1'b0, '0, '0, '0, '0);
          want.last = 1'b1;
          uops_pending = {uops_pending, want};
        end else begin
          crack_instr(mk_stim(in_instr_word, in_op_class, in_addr_mode, in_data_size,
                              in_first_reg, in_first_is_fp, in_second_reg,
                              in_second_is_fp, in_base_reg, in_offset, 1'b0));
        end
      end
    end
    pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    // word, class, mode, size, first reg, fp, second reg, fp, base, offset, typed unsplit
    add_row(mk_stim(32'hFFFF_FFFF, OC_LDR, AM_OFFSET, 5'd8, 5'd2, 1'b0,
                    5'd0, 1'b0, 5'd1, 17'h00010, 1'b1));
    add_row(mk_stim(32'h0000_0000, OC_OTHER, AM_PRE, 5'd4, 5'd31, 1'b1,
                    5'd31, 1'b1, 5'd31, 17'h1FFFF, 1'b1));
    add_row(mk_stim(32'h1234_5678, 3'd5, AM_OFFSET, 5'd8, 5'd1, 1'b0,
                    5'd2, 1'b0, 5'd3, 17'h00008, 1'b1));
    add_row(mk_stim(32'h8765_4321, 3'd7, AM_PRE, 5'd16, 5'd4, 1'b1,
                    5'd5, 1'b1, 5'd6, 17'h10000, 1'b1));
    add_row(mk_stim(32'hA5A5_0001, OC_STR, 2'd3, 5'd8, 5'd7, 1'b0,
                    5'd8, 1'b0, 5'd9, 17'h00020, 1'b1));
    add_row(mk_stim(32'hA5A5_0002, OC_STP, 2'd3, 5'd4, 5'd7, 1'b0,
                    5'd8, 1'b0, 5'd9, 17'h00020, 1'b1));
    add_row(mk_stim(32'hA5A5_0003, 3'd6, AM_POST, 5'd4, 5'd7, 1'b0,
                    5'd8, 1'b0, 5'd9, 17'h00020, 1'b1));
    // Load pairs: base overlap, zero register against SP, FP register with equal number.
    add_row(mk_stim(32'hC000_0001, OC_LDP, AM_OFFSET, 5'd8, 5'd3, 1'b0,
                    5'd4, 1'b0, 5'd3, 17'h00010, 1'b0));
    add_row(mk_stim(32'hC000_0002, OC_LDP, AM_OFFSET, 5'd8, 5'd31, 1'b0,
                    5'd4, 1'b0, 5'd31, 17'h00010, 1'b0));
    add_row(mk_stim(32'hC000_0003, OC_LDP, AM_OFFSET, 5'd16, 5'd5, 1'b1,
                    5'd6, 1'b1, 5'd5, 17'h1FFF0, 1'b0));
    add_row(mk_stim(32'hC000_0004, OC_LDP, AM_PRE, 5'd16, 5'd7, 1'b0,
                    5'd8, 1'b0, 5'd7, 17'h10000, 1'b0));
    add_row(mk_stim(32'hC000_0005, OC_LDP, AM_POST, 5'd16, 5'd9, 1'b0,
                    5'd10, 1'b1, 5'd11, 17'h0FFFF, 1'b0));
    add_row(mk_stim(32'hC000_0006, OC_LDP, AM_OFFSET, 5'd16, 5'd29, 1'b0,
                    5'd30, 1'b0, 5'd29, 17'h0FFFF, 1'b0));
    add_row(mk_stim(32'hC000_0007, OC_LDP, AM_OFFSET, 5'd31, 5'd30, 1'b0,
                    5'd29, 1'b0, 5'd30, 17'h10000, 1'b0));
    // Store pairs with out-of-range sizes and offset extremes.
    add_row(mk_stim(32'hD000_0001, OC_STP, AM_OFFSET, 5'd31, 5'd12, 1'b0,
                    5'd13, 1'b0, 5'd14, 17'h0FFFF, 1'b0));
    add_row(mk_stim(32'hD000_0002, OC_STP, AM_PRE, 5'd0, 5'd15, 1'b0,
                    5'd16, 1'b0, 5'd31, 17'h10000, 1'b0));
    add_row(mk_stim(32'hD000_0003, OC_STP, AM_POST, 5'd17, 5'd17, 1'b1,
                    5'd18, 1'b1, 5'd19, 17'h00040, 1'b0));
    // Singles.
    add_row(mk_stim(32'hE000_0001, OC_LDR, AM_PRE, 5'd1, 5'd31, 1'b0,
                    5'd0, 1'b0, 5'd20, 17'h1FFFF, 1'b0));
    add_row(mk_stim(32'hE000_0002, OC_LDR, AM_POST, 5'd2, 5'd31, 1'b1,
                    5'd0, 1'b0, 5'd21, 17'h00100, 1'b0));
    add_row(mk_stim(32'hE000_0003, OC_STR, AM_OFFSET, 5'd4, 5'd22, 1'b0,
                    5'd0, 1'b0, 5'd22, 17'h0FFFF, 1'b0));
    add_row(mk_stim(32'hE000_0004, OC_STR, AM_PRE, 5'd8, 5'd23, 1'b1,
                    5'd0, 1'b0, 5'd31, 17'h10000, 1'b0));
    add_row(mk_stim(32'hE000_0005, OC_STR, AM_POST, 5'd16, 5'd24, 1'b0,
                    5'd0, 1'b0, 5'd25, 17'h1FFFF, 1'b0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 16;
    recv_idle_pct = 45;
    foreach (directed_rows[i]) send_instr(directed_rows[i]);
    wait_idle();
    set_split(1'b0);
    repeat (10) send_instr(rand_stim());
    wait_idle();
    set_split(1'b1);
    repeat (20) send_instr(rand_stim());

    send_idle_pct = 45;
    recv_idle_pct = 16;
    repeat (12) send_instr(rand_stim());
    // Let the pipeline run completely dry before continuing.
    wait_idle();
    repeat (14) send_instr(rand_stim());

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (22) send_instr(rand_stim());
    wait_idle();

    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
